// ----- rtl/core/b64d_pkg.sv -----
// ----------------------------------------------------------------------------
// b64d_pkg: shared types and constants of the strict base64 decoder
// Symbol classes, status codes, queue entry and result formats, default depths.
// ----------------------------------------------------------------------------
`default_nettype none

package b64d_pkg;

  // Default depths of the internal queues
  localparam int MID_DEPTH_DEFAULT = 4;
  localparam int OUT_DEPTH_DEFAULT = 2;

  // Padding character
  localparam logic [7:0] PAD_SYMBOL = 8'h3D;

  // Class of one text symbol
  typedef enum logic [1:0] {
    CLS_SEXTET = 2'b00,
    CLS_PAD    = 2'b01,
    CLS_BAD    = 2'b10
  } sym_class_t;

  // End-of-string status codes
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_SYMBOL  = 2'd1,
    ST_PADDING = 2'd2,
    ST_LENGTH  = 2'd3
  } status_t;

  // Classified symbol handed from front to back
  typedef struct packed {
    sym_class_t  cls;
    logic [5:0]  sextet;
    logic        last;
  } class_entry_t;

  // One result item
  typedef struct packed {
    logic        is_status;
    logic [7:0]  data_byte;
    status_t     status;
    logic        end_of_run;
  } result_t;

endpackage

`default_nettype wire

// ----- rtl/core/b64d_queue.sv -----
// ----------------------------------------------------------------------------
// b64d_queue: small register queue
// First-in first-out buffer of WIDTH-bit entries with push/full, pop/empty.
// ----------------------------------------------------------------------------
`default_nettype none

module b64d_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  full,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] pop_data,
  output logic                  empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR   = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full     = (count == FULL_COUNT);
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem[rd_ptr];

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/b64d_front.sv -----
// ----------------------------------------------------------------------------
// b64d_front: symbol classifier
// Maps each accepted text byte to a sextet, padding or bad class.
// ----------------------------------------------------------------------------
`default_nettype none

module b64d_front (
  input  wire logic [7:0]       symbol,
  input  wire logic             last,
  output b64d_pkg::class_entry_t entry
);

  logic [7:0] upper_off;
  logic [7:0] lower_off;
  logic [7:0] digit_off;

  assign upper_off = symbol - 8'h41;
  assign lower_off = symbol - 8'h61 + 8'd26;
  assign digit_off = symbol - 8'h30 + 8'd52;

  // Classify the symbol against the standard alphabet
  always_comb begin
    entry.last   = last;
    entry.cls    = b64d_pkg::CLS_SEXTET;
    entry.sextet = '0;
    if (symbol >= 8'h41 && symbol <= 8'h5A) begin
      entry.sextet = upper_off[5:0];
    end else if (symbol >= 8'h61 && symbol <= 8'h7A) begin
      entry.sextet = lower_off[5:0];
    end else if (symbol >= 8'h30 && symbol <= 8'h39) begin
      entry.sextet = digit_off[5:0];
    end else if (symbol == 8'h2B) begin
      entry.sextet = 6'd62;
    end else if (symbol == 8'h2F) begin
      entry.sextet = 6'd63;
    end else if (symbol == b64d_pkg::PAD_SYMBOL) begin
      entry.cls = b64d_pkg::CLS_PAD;
    end else begin
      entry.cls = b64d_pkg::CLS_BAD;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/b64d_back.sv -----
// ----------------------------------------------------------------------------
// b64d_back: decode engine
// Gathers sextets into bytes, tracks padding and errors, issues results.
// ----------------------------------------------------------------------------
`default_nettype none

module b64d_back (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   mid_empty,
  input  wire b64d_pkg::class_entry_t mid_entry,
  output logic                        mid_pop,
  input  wire logic                   out_full,
  output logic                        out_push,
  output b64d_pkg::result_t           out_result
);

  logic [11:0]       bit_buffer, bit_buffer_next;
  logic [3:0]        bit_count, bit_count_next;
  logic [1:0]        symbol_phase, symbol_phase_next;
  logic [1:0]        pad_count, pad_count_next;
  logic              pad_seen, pad_seen_next;
  b64d_pkg::status_t error_code, error_code_next;
  logic              hold_valid, hold_valid_next;
  b64d_pkg::result_t hold_result, hold_result_next;

  // Decode one entry, or drain a held status
  always_comb begin
    logic [11:0]       buf_new;
    logic [3:0]        cnt_new;
    logic              byte_valid;
    logic [7:0]        byte_val;
    b64d_pkg::status_t err_new;
    logic [1:0]        phase_new;
    b64d_pkg::result_t byte_res;
    b64d_pkg::result_t stat_res;

    bit_buffer_next   = bit_buffer;
    bit_count_next    = bit_count;
    symbol_phase_next = symbol_phase;
    pad_count_next    = pad_count;
    pad_seen_next     = pad_seen;
    error_code_next   = error_code;
    hold_valid_next   = hold_valid;
    hold_result_next  = hold_result;
    mid_pop           = 1'b0;
    out_push          = 1'b0;
    out_result        = hold_result;

    buf_new    = {bit_buffer[5:0], mid_entry.sextet};
    cnt_new    = bit_count + 4'd6;
    byte_valid = 1'b0;
    err_new    = error_code;
    phase_new  = symbol_phase + 2'd1;
    byte_val   = '0;

    byte_res.is_status  = 1'b0;
    byte_res.data_byte  = '0;
    byte_res.status     = b64d_pkg::ST_OK;
    byte_res.end_of_run = !mid_entry.last;
    stat_res.is_status  = 1'b1;
    stat_res.data_byte  = '0;
    stat_res.status     = b64d_pkg::ST_OK;
    stat_res.end_of_run = 1'b1;

    if (hold_valid) begin
      if (!out_full) begin
        out_push        = 1'b1;
        hold_valid_next = 1'b0;
      end
    end else if (!mid_empty && !out_full) begin
      mid_pop           = 1'b1;
      symbol_phase_next = phase_new;
      if (error_code == b64d_pkg::ST_OK) begin
        if (mid_entry.cls == b64d_pkg::CLS_PAD) begin
          if (pad_count >= 2'd2) begin
            err_new = b64d_pkg::ST_PADDING;
          end else begin
            pad_count_next = pad_count + 2'd1;
            pad_seen_next  = 1'b1;
          end
        end else if (pad_seen) begin
          err_new = b64d_pkg::ST_PADDING;
        end else if (mid_entry.cls == b64d_pkg::CLS_BAD) begin
          err_new = b64d_pkg::ST_SYMBOL;
        end else begin
          bit_buffer_next = buf_new;
          if (cnt_new >= 4'd8) begin
            cnt_new    = cnt_new - 4'd8;
            byte_valid = 1'b1;
            byte_val   = 8'(buf_new >> cnt_new);
          end
          bit_count_next = cnt_new;
        end
      end
      error_code_next    = err_new;
      byte_res.data_byte = byte_val;
      stat_res.status    = (phase_new != 2'd0) ? b64d_pkg::ST_LENGTH : err_new;

      // Issue byte first; a status behind it is held and sent after the byte
      if (byte_valid) begin
        out_push   = 1'b1;
        out_result = byte_res;
        if (mid_entry.last) begin
          hold_valid_next  = 1'b1;
          hold_result_next = stat_res;
        end
      end else if (mid_entry.last) begin
        out_push   = 1'b1;
        out_result = stat_res;
      end

      // Clear string state after the final symbol
      if (mid_entry.last) begin
        bit_buffer_next   = '0;
        bit_count_next    = '0;
        symbol_phase_next = '0;
        pad_count_next    = '0;
        pad_seen_next     = 1'b0;
        error_code_next   = b64d_pkg::ST_OK;
      end
    end
  end

  // Hold string state
  always_ff @(posedge clk) begin
    if (rst) begin
      bit_buffer   <= '0;
      bit_count    <= '0;
      symbol_phase <= '0;
      pad_count    <= '0;
      pad_seen     <= 1'b0;
      error_code   <= b64d_pkg::ST_OK;
      hold_valid   <= 1'b0;
    end else begin
      bit_buffer   <= bit_buffer_next;
      bit_count    <= bit_count_next;
      symbol_phase <= symbol_phase_next;
      pad_count    <= pad_count_next;
      pad_seen     <= pad_seen_next;
      error_code   <= error_code_next;
      hold_valid   <= hold_valid_next;
    end
  end

  // Held status payload
  always_ff @(posedge clk) begin
    hold_result <= hold_result_next;
  end

endmodule

`default_nettype wire

// ----- rtl/core/base64_strict_decoder.sv -----
// ----------------------------------------------------------------------------
// base64_strict_decoder: streaming strict base64 decoder
// Takes one text symbol per cycle while not full and returns decoded bytes plus a status.
// ----------------------------------------------------------------------------
// One symbol is accepted per clock while the input queue is not full. A
// classifier maps it into a short queue; the decode engine takes one entry
// and writes one result per cycle into a small output queue, unless that
// queue is full or a status is held. A final symbol that also completes a
// byte gives byte, then status, through the single write port of the output
// queue. A symbol's first result passes both queue registers before it shows.
// Bytes are sent as they are decoded and stop at the first error; discard the
// bytes of a string whose status is not ok. Status: 0 ok, 1 bad symbol, 2
// misplaced padding, 3 length not a multiple of four (this one takes priority).
`default_nettype none

module base64_strict_decoder #(
  parameter int MID_DEPTH = b64d_pkg::MID_DEPTH_DEFAULT,
  parameter int OUT_DEPTH = b64d_pkg::OUT_DEPTH_DEFAULT
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] symbol,
  input  wire logic       last,
  input  wire logic       pop,
  output logic            empty,
  output logic            is_status,
  output logic      [7:0] data_byte,
  output logic      [1:0] status,
  output logic            end_of_run
);

  b64d_pkg::class_entry_t front_entry;
  b64d_pkg::class_entry_t mid_entry;
  logic                   mid_empty;
  logic                   mid_pop;
  logic                   out_full;
  logic                   out_push;
  b64d_pkg::result_t      back_result;
  b64d_pkg::result_t      out_result;

  // Classify incoming symbols
  b64d_front u_front (
    .symbol (symbol),
    .last   (last),
    .entry  (front_entry)
  );

  // Decouple front from back
  b64d_queue #(
    .WIDTH ($bits(b64d_pkg::class_entry_t)),
    .DEPTH (MID_DEPTH)
  ) u_mid_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (front_entry),
    .full      (full),
    .pop       (mid_pop),
    .pop_data  (mid_entry),
    .empty     (mid_empty)
  );

  // Decode and issue results
  b64d_back u_back (
    .clk        (clk),
    .rst        (rst),
    .mid_empty  (mid_empty),
    .mid_entry  (mid_entry),
    .mid_pop    (mid_pop),
    .out_full   (out_full),
    .out_push   (out_push),
    .out_result (back_result)
  );

  // Buffer results toward the consumer
  b64d_queue #(
    .WIDTH ($bits(b64d_pkg::result_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (out_push),
    .push_data (back_result),
    .full      (out_full),
    .pop       (pop),
    .pop_data  (out_result),
    .empty     (empty)
  );

  assign is_status  = out_result.is_status;
  assign data_byte  = out_result.data_byte;
  assign status     = out_result.status;
  assign end_of_run = out_result.end_of_run;

endmodule

`default_nettype wire

// ----- rtl/core/b64d_checker.sv -----
// ----------------------------------------------------------------------------
// b64d_checker: port-level checks of the strict base64 decoder
// Watches the result side for format and ordering slips.
// ----------------------------------------------------------------------------
`default_nettype none

module b64d_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       full,
  input wire logic       pop,
  input wire logic       empty,
  input wire logic       is_status,
  input wire logic [7:0] data_byte,
  input wire logic [1:0] status,
  input wire logic       end_of_run
);

  // Drop all waiting results and open the input on reset
  a_reset_idle: assert property (@(posedge clk) rst |=> (empty && !full))
    else $error("queues not idle after reset");

  // A status result carries no byte and closes the run
  a_status_format: assert property (@(posedge clk) disable iff (rst)
    (!empty && is_status) |-> (data_byte == 8'd0 && end_of_run))
    else $error("malformed status result");

  // A byte not closing its run is followed by more results of that symbol
  a_byte_then_more: assert property (@(posedge clk) disable iff (rst)
    (!empty && pop && !is_status && !end_of_run) |=> (!empty && is_status))
    else $error("byte of a final symbol not followed by its status");

  // Hold a stalled result
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(is_status) && $stable(data_byte)
                          && $stable(status) && $stable(end_of_run)))
    else $error("stalled result changed");

endmodule

bind base64_strict_decoder b64d_checker u_b64d_checker (.*);

`default_nettype wire
